// ----- src/pttt_pkg.sv -----
// Shared widths, defaults and codes of the periodic task timer table.
`default_nettype none
package pttt_pkg;

    localparam int NUM_SLOTS_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int MAX_RESULTS     = 8;

    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 3;
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK   = 2'd0,
        FN_ADD    = 2'd1,
        FN_REMOVE = 2'd2,
        FN_RUN    = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED         = 3'd0,
        ST_ADD_REJECT    = 3'd1,
        ST_REMOVED       = 3'd2,
        ST_REMOVE_ABSENT = 3'd3,
        ST_TICK_DONE     = 3'd4,
        ST_TASK_DUE      = 3'd5,
        ST_NONE_DUE      = 3'd6
    } t_status;

endpackage
`default_nettype wire

// ----- src/pttt_if.sv -----
// Request and result channel interfaces of the periodic task timer table.
`default_nettype none
interface pttt_req_if;
    import pttt_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [SLOT_W-1:0]  slot;
    logic [FIELD_W-1:0] first_expire;
    logic [FIELD_W-1:0] reload_period;

    modport source (output valid, output func, output slot, output first_expire,
                    output reload_period, input ready);
    modport sink   (input valid, input func, input slot, input first_expire,
                    input reload_period, output ready);
endinterface

interface pttt_res_if;
    import pttt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   task_slot;
    logic                is_last;

    modport source (output valid, output status, output task_slot, output is_last,
                    input ready);
    modport sink   (input valid, input status, input task_slot, input is_last,
                    output ready);
endinterface
`default_nettype wire

// ----- src/periodic_task_timer_table.sv -----
// Periodic task timer table: slot table of countdown tasks with add, remove, tick and run.
//
// Requests arrive on i_req (func, slot, first_expire, reload_period) and results leave
// on o_res (status, task_slot, is_last); a transaction completes when valid and ready
// are both high. The last result of each request carries is_last.
// Add, remove and a run with nothing due answer from the slot flags: the result is
// registered at the accepting edge and shows on o_res in the next cycle.
// A tick walks every slot through one shared decrement unit and the count/period RAM,
// one slot per cycle with a registered RAM read, then S_TWB and S_TDONE give the result.
// A run scans one slot per cycle, waiting at a due slot while the output is stalled, and
// returns one result per due slot, at most eight.
// i_req.ready is high only while no request is in work and the output register is free
// or being emptied; a stalled receiver holds the result and pauses the sequencer.
// Reset frees every slot and clears every due mark; the RAM needs no clearing pass,
// since an entry is used only for an active slot, which an add has written.
`default_nettype none
module periodic_task_timer_table #(
    parameter int NUM_SLOTS   = pttt_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_WIDTH = pttt_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pttt_req_if.sink    i_req,
    pttt_res_if.source  o_res
);
    import pttt_pkg::*;

    localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IW    = (SW > SLOT_W) ? SW : SLOT_W;
    localparam int IW1   = IW + 1;
    localparam int CNT_W = $clog2(MAX_RESULTS);
    localparam int MW    = 2 * COUNT_WIDTH;
    localparam logic [SW-1:0]    LAST_SLOT  = SW'(NUM_SLOTS - 1);
    localparam logic [IW:0]      NUM_SLOT_V = IW1'(NUM_SLOTS);
    localparam logic [CNT_W-1:0] LAST_CNT   = CNT_W'(MAX_RESULTS - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TICK  = 5'b00010,
        S_TWB   = 5'b00100,
        S_TDONE = 5'b01000,
        S_RUN   = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [NUM_SLOTS-1:0]   r_active, n_active;
    logic [NUM_SLOTS-1:0]   r_due, n_due;
    logic [NUM_SLOTS-1:0]   r_oneshot, n_oneshot;
    logic [NUM_SLOTS-1:0]   r_pend, n_pend;
    logic [SW-1:0]          r_ptr, n_ptr;
    logic [SW-1:0]          r_wb_ptr, n_wb_ptr;
    logic                   r_wb_valid, n_wb_valid;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_out_valid, n_out_valid;
    t_status                r_out_status, n_out_status;
    logic [SLOT_W-1:0]      r_out_slot, n_out_slot;
    logic                   r_out_last, n_out_last;

    logic [MW-1:0]          r_mem [NUM_SLOTS];
    logic [MW-1:0]          r_rd_data;
    logic                   mem_we;
    logic [SW-1:0]          wr_addr;
    logic [MW-1:0]          wr_data;

    logic [COUNT_WIDTH-1:0] tu_count;
    logic                   tu_due;
    logic                   out_free;
    logic                   accept;
    logic [IW-1:0]          slot_ext;
    logic [SW-1:0]          idx;
    logic                   in_range;
    logic [COUNT_WIDTH-1:0] add_first;
    logic [COUNT_WIDTH-1:0] add_reload;
    logic [NUM_SLOTS-1:0]   ptr_hot;
    logic                   run_last;
    logic                   wb_en;

    pttt_tick_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tick_unit (
        .i_count  (r_rd_data[COUNT_WIDTH-1:0]),
        .i_period (r_rd_data[MW-1:COUNT_WIDTH]),
        .o_count  (tu_count),
        .o_due    (tu_due)
    );

    assign out_free    = !r_out_valid || o_res.ready;
    assign i_req.ready = i_rst_n && (r_state == S_IDLE) && out_free;
    assign accept      = i_req.valid && i_req.ready;

    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_out_status;
    assign o_res.task_slot = r_out_slot;
    assign o_res.is_last   = r_out_last;

    always_comb begin
        slot_ext   = IW'(i_req.slot);
        idx        = slot_ext[SW-1:0];
        in_range   = ({1'b0, slot_ext} < NUM_SLOT_V);
        add_first  = COUNT_WIDTH'(i_req.first_expire);
        add_reload = COUNT_WIDTH'(i_req.reload_period);
        ptr_hot    = '0;
        ptr_hot[r_ptr] = 1'b1;
        run_last   = (r_cnt == LAST_CNT) || ((r_pend & ~ptr_hot) == '0);
        wb_en      = ((r_state == S_TICK) || (r_state == S_TWB)) && r_wb_valid
                     && r_active[r_wb_ptr];
    end

    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_due        = r_due;
        n_oneshot    = r_oneshot;
        n_pend       = r_pend;
        n_ptr        = r_ptr;
        n_wb_ptr     = r_wb_ptr;
        n_wb_valid   = r_wb_valid;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        wr_addr      = idx;
        wr_data      = {add_reload, add_first};

        if (wb_en) begin
            mem_we  = 1'b1;
            wr_addr = r_wb_ptr;
            wr_data = {r_rd_data[MW-1:COUNT_WIDTH], tu_count};
            if (tu_due) begin
                n_due[r_wb_ptr] = 1'b1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                n_wb_valid = 1'b0;
                if (accept) begin
                    n_out_slot = i_req.slot;
                    n_out_last = 1'b1;
                    case (t_func'(i_req.func))
                        FN_TICK: begin
                            n_ptr   = '0;
                            n_state = S_TICK;
                        end
                        FN_ADD: begin
                            n_out_valid = 1'b1;
                            if (in_range && !r_active[idx]) begin
                                n_active[idx]  = 1'b1;
                                n_due[idx]     = 1'b0;
                                n_oneshot[idx] = (add_reload == '0);
                                mem_we         = 1'b1;
                                n_out_status   = ST_ADDED;
                            end else begin
                                n_out_status = ST_ADD_REJECT;
                            end
                        end
                        FN_REMOVE: begin
                            n_out_valid = 1'b1;
                            if (in_range && r_active[idx]) begin
                                n_active[idx] = 1'b0;
                                n_due[idx]    = 1'b0;
                                n_out_status  = ST_REMOVED;
                            end else begin
                                n_out_status = ST_REMOVE_ABSENT;
                            end
                        end
                        default: begin
                            if ((r_active & r_due) == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_NONE_DUE;
                                n_out_slot   = '0;
                            end else begin
                                n_pend  = r_active & r_due;
                                n_ptr   = '0;
                                n_cnt   = '0;
                                n_state = S_RUN;
                            end
                        end
                    endcase
                end
            end
            S_TICK: begin
                n_wb_valid = 1'b1;
                n_wb_ptr   = r_ptr;
                if (r_ptr == LAST_SLOT) begin
                    n_state = S_TWB;
                end else begin
                    n_ptr = r_ptr + SW'(1);
                end
            end
            S_TWB: begin
                n_wb_valid = 1'b0;
                n_state    = S_TDONE;
            end
            S_TDONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_TICK_DONE;
                    n_out_slot   = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RUN: begin
                if (r_pend[r_ptr]) begin
                    if (out_free) begin
                        n_out_valid    = 1'b1;
                        n_out_status   = ST_TASK_DUE;
                        n_out_slot     = SLOT_W'(r_ptr);
                        n_out_last     = run_last;
                        n_due[r_ptr]   = 1'b0;
                        n_pend[r_ptr]  = 1'b0;
                        n_cnt          = r_cnt + CNT_W'(1);
                        if (r_oneshot[r_ptr]) begin
                            n_active[r_ptr] = 1'b0;
                        end
                        if (run_last || (r_ptr == LAST_SLOT)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_ptr = r_ptr + SW'(1);
                        end
                    end
                end else if (r_ptr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + SW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_due       <= '0;
            r_pend      <= '0;
            r_ptr       <= '0;
            r_wb_ptr    <= '0;
            r_wb_valid  <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_due       <= n_due;
            r_pend      <= n_pend;
            r_ptr       <= n_ptr;
            r_wb_ptr    <= n_wb_ptr;
            r_wb_valid  <= n_wb_valid;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oneshot    <= n_oneshot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_ptr];
    end
endmodule
`default_nettype wire

// ----- src/pttt_tick_unit.sv -----
// Shared countdown unit: decrement one slot count, detect expiry and reload.
`default_nettype none
module pttt_tick_unit #(
    parameter int COUNT_WIDTH = pttt_pkg::COUNT_WIDTH_DEF
) (
    input  logic [COUNT_WIDTH-1:0] i_count,
    input  logic [COUNT_WIDTH-1:0] i_period,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic                   o_due
);
    logic [COUNT_WIDTH-1:0] dec;

    always_comb begin
        dec   = i_count - COUNT_WIDTH'(1);
        o_due = (dec == '0);
        if (o_due && (i_period != '0)) begin
            o_count = i_period;
        end else begin
            o_count = dec;
        end
    end
endmodule
`default_nettype wire

// ----- bench/periodic_task_timer_table_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the periodic task timer table: directed table then random traffic.
module periodic_task_timer_table_tb;
    import pttt_pkg::*;

    typedef struct packed {
        t_func              func;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] first_expire;
        logic [FIELD_W-1:0] reload_period;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] task_slot;
        logic              is_last;
    } t_res;

    typedef struct packed {
        t_req              item;
        logic              typed;
        t_status           status;
        logic [SLOT_W-1:0] task_slot;
    } t_dir_row;

    localparam int NUM_DIR = 26;
    localparam int NUM_RND = 360;

    logic i_clk;
    logic i_rst_n;

    pttt_req_if req_if ();
    pttt_res_if res_if ();

    periodic_task_timer_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    logic               slot_busy  [NUM_SLOTS_DEF];
    logic [FIELD_W-1:0] count_left [NUM_SLOTS_DEF];
    logic [FIELD_W-1:0] period     [NUM_SLOTS_DEF];
    logic               due_flag   [NUM_SLOTS_DEF];

    t_res  staged_q[$];
    t_res  expected_q[$];
    bit    steady;
    int    err_cnt;
    int    sent_cnt;
    int    checked_cnt;
    int    due_cnt;

    t_dir_row dir_rows [NUM_DIR] = '{
        '{'{FN_RUN,    3'd0, 16'h0000, 16'h0000}, 1'b1, ST_NONE_DUE,      3'd0},
        '{'{FN_TICK,   3'd0, 16'h0000, 16'h0000}, 1'b1, ST_TICK_DONE,     3'd0},
        '{'{FN_REMOVE, 3'd0, 16'h0000, 16'h0000}, 1'b1, ST_REMOVE_ABSENT, 3'd0},
        '{'{FN_ADD,    3'd0, 16'h0001, 16'h0000}, 1'b1, ST_ADDED,         3'd0},
        '{'{FN_ADD,    3'd0, 16'h0005, 16'h0005}, 1'b1, ST_ADD_REJECT,    3'd0},
        '{'{FN_ADD,    3'd7, 16'hFFFF, 16'hFFFF}, 1'b1, ST_ADDED,         3'd7},
        '{'{FN_ADD,    3'd3, 16'h0000, 16'h0005}, 1'b1, ST_ADDED,         3'd3},
        '{'{FN_ADD,    3'd5, 16'h0002, 16'h0001}, 1'b1, ST_ADDED,         3'd5},
        '{'{FN_TICK,   3'd7, 16'hFFFF, 16'hFFFF}, 1'b1, ST_TICK_DONE,     3'd0},
        '{'{FN_RUN,    3'd7, 16'hFFFF, 16'hFFFF}, 1'b1, ST_TASK_DUE,      3'd0},
        '{'{FN_REMOVE, 3'd0, 16'h0000, 16'h0000}, 1'b1, ST_REMOVE_ABSENT, 3'd0},
        '{'{FN_TICK,   3'd0, 16'h0000, 16'h0000}, 1'b1, ST_TICK_DONE,     3'd0},
        '{'{FN_TICK,   3'd0, 16'h0000, 16'h0000}, 1'b1, ST_TICK_DONE,     3'd0},
        '{'{FN_RUN,    3'd0, 16'h0000, 16'h0000}, 1'b1, ST_TASK_DUE,      3'd5},
        '{'{FN_REMOVE, 3'd7, 16'h0000, 16'h0000}, 1'b1, ST_REMOVED,       3'd7},
        '{'{FN_ADD,    3'd2, 16'h0001, 16'h0003}, 1'b1, ST_ADDED,         3'd2},
        '{'{FN_TICK,   3'd0, 16'h0000, 16'h0000}, 1'b1, ST_TICK_DONE,     3'd0},
        '{'{FN_REMOVE, 3'd2, 16'h0000, 16'h0000}, 1'b1, ST_REMOVED,       3'd2},
        '{'{FN_RUN,    3'd0, 16'h0000, 16'h0000}, 1'b1, ST_TASK_DUE,      3'd5},
        '{'{FN_ADD,    3'd1, 16'h0001, 16'h0000}, 1'b0, ST_ADDED,         3'd0},
        '{'{FN_ADD,    3'd4, 16'h0001, 16'hAAAA}, 1'b0, ST_ADDED,         3'd0},
        '{'{FN_ADD,    3'd6, 16'h0001, 16'h5555}, 1'b0, ST_ADDED,         3'd0},
        '{'{FN_ADD,    3'd0, 16'h0001, 16'h0001}, 1'b0, ST_ADDED,         3'd0},
        '{'{FN_TICK,   3'd0, 16'h0000, 16'h0000}, 1'b0, ST_TICK_DONE,     3'd0},
        '{'{FN_RUN,    3'd0, 16'h0000, 16'h0000}, 1'b0, ST_TASK_DUE,      3'd0},
        '{'{FN_REMOVE, 3'd3, 16'h0000, 16'h0000}, 1'b0, ST_REMOVED,       3'd3}
    };

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic bit idle_hit();
        return !steady && ($urandom_range(0, 99) < 34);
    endfunction

    function automatic void free_task(input int s);
        slot_busy[s]  = 1'b0;
        due_flag[s]   = 1'b0;
        count_left[s] = '0;
        period[s]     = '0;
    endfunction

    function automatic void push_staged(input t_status st, input int s, input logic last);
        t_res r;
        r.status    = st;
        r.task_slot = s[SLOT_W-1:0];
        r.is_last   = last;
        staged_q.push_back(r);
    endfunction

    // Advance the timer table by one request and stage the results it produces.
    function automatic void predict_table(input t_req it);
        int s;
        int n;
        s = int'(it.slot);
        n = 0;
        staged_q.delete();
        case (it.func)
            FN_TICK: begin
                for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
                    if (slot_busy[i]) begin
                        count_left[i] = count_left[i] - 1'b1;
                        if (count_left[i] == '0) begin
                            due_flag[i] = 1'b1;
                            if (period[i] != '0) count_left[i] = period[i];
                        end
                    end
                end
                push_staged(ST_TICK_DONE, 0, 1'b1);
            end
            FN_ADD: begin
                if (s >= NUM_SLOTS_DEF || slot_busy[s]) begin
                    push_staged(ST_ADD_REJECT, s, 1'b1);
                end else begin
                    slot_busy[s]  = 1'b1;
                    due_flag[s]   = 1'b0;
                    count_left[s] = it.first_expire;
                    period[s]     = it.reload_period;
                    push_staged(ST_ADDED, s, 1'b1);
                end
            end
            FN_REMOVE: begin
                if (s >= NUM_SLOTS_DEF || !slot_busy[s]) begin
                    push_staged(ST_REMOVE_ABSENT, s, 1'b1);
                end else begin
                    free_task(s);
                    push_staged(ST_REMOVED, s, 1'b1);
                end
            end
            default: begin
                for (int i = 0; i < NUM_SLOTS_DEF && n < MAX_RESULTS; i++) begin
                    if (slot_busy[i] && due_flag[i]) begin
                        due_flag[i] = 1'b0;
                        if (period[i] == '0) free_task(i);
                        push_staged(ST_TASK_DUE, i, 1'b0);
                        n++;
                    end
                end
                if (n == 0) push_staged(ST_NONE_DUE, 0, 1'b1);
                else staged_q[staged_q.size()-1].is_last = 1'b1;
            end
        endcase
    endfunction

    // Present one request, hold it until accepted, then queue its expected results.
    task automatic send_request(input t_req it, input bit typed, input t_res typed_res);
        while (idle_hit()) @(negedge i_clk);
        req_if.valid         = 1'b1;
        req_if.func          = it.func;
        req_if.slot          = it.slot;
        req_if.first_expire  = it.first_expire;
        req_if.reload_period = it.reload_period;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_table(it);
        if (typed) expected_q.push_back(typed_res);
        else foreach (staged_q[k]) expected_q.push_back(staged_q[k]);
        sent_cnt++;
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    function automatic t_req random_request();
        t_req it;
        int   pick;
        int   roll;
        it.slot          = SLOT_W'($urandom_range(0, NUM_SLOTS_DEF - 1));
        it.first_expire  = FIELD_W'($urandom());
        it.reload_period = FIELD_W'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.func = FN_TICK;
        end else if (pick < 65) begin
            it.func = FN_ADD;
            roll = $urandom_range(0, 99);
            if (roll < 85) it.first_expire = FIELD_W'($urandom_range(1, 6));
            else if (roll < 95) it.first_expire = FIELD_W'($urandom());
            else it.first_expire = '0;
            roll = $urandom_range(0, 99);
            if (roll < 40) it.reload_period = '0;
            else if (roll < 85) it.reload_period = FIELD_W'($urandom_range(1, 8));
        end else if (pick < 77) begin
            it.func = FN_REMOVE;
        end else begin
            it.func = FN_RUN;
        end
        return it;
    endfunction

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready = !idle_hit();
        end
    end

    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d slot=%0d last=%0d", $time,
                         res_if.status, res_if.task_slot, res_if.is_last);
                err_cnt++;
            end else begin
                exp_r = expected_q.pop_front();
                checked_cnt++;
                if (exp_r.status == ST_TASK_DUE) due_cnt++;
                if (res_if.status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, res_if.status);
                    err_cnt++;
                end
                if (res_if.task_slot !== exp_r.task_slot) begin
                    $display("%0t: task_slot expected %0d actual %0d", $time,
                             exp_r.task_slot, res_if.task_slot);
                    err_cnt++;
                end
                if (res_if.is_last !== exp_r.is_last) begin
                    $display("%0t: is_last expected %0d actual %0d", $time,
                             exp_r.is_last, res_if.is_last);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #1_600_000;
        $display("periodic_task_timer_table_tb: errors");
        $finish;
    end

    initial begin
        t_res typed_res;
        int   drain;
        steady               = 1'b0;
        err_cnt              = 0;
        sent_cnt             = 0;
        checked_cnt          = 0;
        due_cnt              = 0;
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.func          = FN_TICK;
        req_if.slot          = '0;
        req_if.first_expire  = '0;
        req_if.reload_period = '0;
        for (int i = 0; i < NUM_SLOTS_DEF; i++) free_task(i);
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            typed_res.status    = dir_rows[r].status;
            typed_res.task_slot = dir_rows[r].task_slot;
            typed_res.is_last   = 1'b1;
            send_request(dir_rows[r].item, dir_rows[r].typed, typed_res);
        end

        for (int k = 0; k < NUM_RND; k++) begin
            steady = (k >= 120 && k < 200);
            send_request(random_request(), 1'b0, typed_res);
        end
        steady = 1'b0;

        drain = 0;
        while (expected_q.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (4 * (NUM_SLOTS_DEF + 3)) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_q.size());
            err_cnt++;
        end

        $display("%0d requests sent (directed table plus random), %0d results checked,",
                 sent_cnt, checked_cnt);
        $display("%0d task-due reports among them, %0d mismatches", due_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("periodic_task_timer_table_tb: clean");
        end else begin
            $display("periodic_task_timer_table_tb: errors");
        end
        $finish;
    end

endmodule

// ----- periodic_task_timer_table.f -----
src/pttt_pkg.sv
src/pttt_if.sv
src/pttt_tick_unit.sv
src/periodic_task_timer_table.sv
bench/periodic_task_timer_table_tb.sv
